FILE: rtl/dq_pkg.sv
// Package for the double-ended queue core.
// Holds command and status codes, default sizes and the result control struct.
// No dependencies.
package dq_pkg;

  // Default sizes.
  localparam int DQ_CAPACITY   = 16;
  localparam int DQ_DATA_WIDTH = 32;

  // Command codes carried by an input item.
  localparam logic [2:0] CMD_INS_FRONT = 3'd0;
  localparam logic [2:0] CMD_INS_REAR  = 3'd1;
  localparam logic [2:0] CMD_DEL_FRONT = 3'd2;
  localparam logic [2:0] CMD_DEL_REAR  = 3'd3;
  localparam logic [2:0] CMD_LIST      = 3'd4;

  // Status codes carried by a result item.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Control half of a result handed from the controller to the output stage.
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic       last;
    logic       from_ram;
  } res_t;

endpackage

FILE: rtl/dq_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/dq_ctrl.sv
// Queue controller: front index, occupancy, command decode and the list walker.
// Depends on dq_pkg; drives the ports of the slot memory.
module dq_ctrl #(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [2:0]                  command,
  input  logic signed [DATA_WIDTH-1:0] value,
  input  logic                        out_free,
  output dq_pkg::res_t                res,
  output logic                        wr_en,
  output logic [$clog2(CAPACITY)-1:0] wr_addr,
  output logic [DATA_WIDTH-1:0]       wr_data,
  output logic                        rd_en,
  output logic [$clog2(CAPACITY)-1:0] rd_addr
);
  import dq_pkg::*;

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [IW-1:0] IDX_LAST = IW'(CAPACITY - 1);
  localparam logic [IW:0]   CAP_WIDE = (IW + 1)'(CAPACITY);
  localparam logic [CW-1:0] OCC_FULL = CW'(CAPACITY);

  // Controller states.
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LIST = 1'b1;

  logic          state, state_next;
  logic [IW-1:0] front, front_next;
  logic [CW-1:0] occ, occ_next;
  logic [IW-1:0] pos, pos_next;
  logic [CW-1:0] cnt, cnt_next;

  logic          accept;
  logic          is_full;
  logic          is_empty;
  logic [IW-1:0] front_dec;
  logic [IW-1:0] front_inc;
  logic [IW-1:0] pos_inc;
  logic [IW:0]   rear_sum;
  logic [IW-1:0] rear;
  logic          list_last;

  assign in_stall = (state == ST_LIST) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign is_full  = (occ == OCC_FULL);
  assign is_empty = (occ == '0);

  // Ring index arithmetic, wrapping at the capacity.
  assign front_dec = (front == '0) ? IDX_LAST : front - 1'b1;
  assign front_inc = (front == IDX_LAST) ? '0 : front + 1'b1;
  assign pos_inc   = (pos == IDX_LAST) ? '0 : pos + 1'b1;
  assign rear_sum  = (IW + 1)'(front) + (IW + 1)'(occ);
  assign rear      = (rear_sum >= CAP_WIDE) ? IW'(rear_sum - CAP_WIDE) : IW'(rear_sum);
  assign list_last = (CW'(cnt + 1'b1) == occ);

  assign wr_data = value;

  // Command decode and list sequencing.
  always_comb begin
    state_next = state;
    front_next = front;
    occ_next   = occ;
    pos_next   = pos;
    cnt_next   = cnt;
    res        = '0;
    wr_en      = 1'b0;
    wr_addr    = rear;
    rd_en      = 1'b0;
    rd_addr    = front;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (command)
            CMD_INS_FRONT: begin
              res.valid = 1'b1;
              res.last  = 1'b1;
              if (is_full) begin
                res.status = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = front_dec;
                front_next = front_dec;
                occ_next   = occ + 1'b1;
                res.status = ST_OK;
              end
            end
            CMD_INS_REAR: begin
              res.valid = 1'b1;
              res.last  = 1'b1;
              if (is_full) begin
                res.status = ST_FULL;
              end else begin
                wr_en      = 1'b1;
                wr_addr    = rear;
                occ_next   = occ + 1'b1;
                res.status = ST_OK;
              end
            end
            CMD_DEL_FRONT: begin
              res.valid = 1'b1;
              res.last  = 1'b1;
              if (is_empty) begin
                res.status = ST_EMPTY;
              end else begin
                front_next = front_inc;
                occ_next   = occ - 1'b1;
                res.status = ST_OK;
              end
            end
            CMD_DEL_REAR: begin
              res.valid = 1'b1;
              res.last  = 1'b1;
              if (is_empty) begin
                res.status = ST_EMPTY;
              end else begin
                occ_next   = occ - 1'b1;
                res.status = ST_OK;
              end
            end
            CMD_LIST: begin
              if (is_empty) begin
                res.valid  = 1'b1;
                res.last   = 1'b1;
                res.status = ST_EMPTY;
              end else begin
                // Fetch the front element; the output stage takes it from the read data.
                rd_en      = 1'b1;
                rd_addr    = front;
                pos_next   = front;
                cnt_next   = '0;
                state_next = ST_LIST;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_LIST: begin
        // The read data is held until the output stage takes it.
        if (out_free) begin
          res.valid    = 1'b1;
          res.status   = ST_OK;
          res.last     = list_last;
          res.from_ram = 1'b1;
          if (list_last) begin
            state_next = ST_IDLE;
          end else begin
            rd_en    = 1'b1;
            rd_addr  = pos_inc;
            pos_next = pos_inc;
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Queue state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      front <= '0;
      occ   <= '0;
      pos   <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      front <= front_next;
      occ   <= occ_next;
      pos   <= pos_next;
      cnt   <= cnt_next;
    end
  end

endmodule

FILE: rtl/dq_outreg.sv
// Output register stage for result items.
// Depends on dq_pkg; takes the element from the slot memory's read data.
module dq_outreg #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dq_pkg::res_t                 res,
  input  logic [DATA_WIDTH-1:0]        rd_data,
  output logic                         out_free,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic signed [DATA_WIDTH-1:0] element,
  output logic                         last
);
  import dq_pkg::*;

  assign out_free = !out_valid || !out_stall;

  // Valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res.valid;
    end
  end

  // Payload; the element is zero unless the item comes from a list walk.
  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      status  <= res.status;
      last    <= res.last;
      element <= res.from_ram ? rd_data : '0;
    end
  end

endmodule

FILE: rtl/double_ended_queue_core.sv
// Bounded double-ended queue of signed words held in a ring buffer in one
// synchronous RAM, addressed by a front index and an occupancy count. Inserts,
// deletes and unused command codes are handled without a walk, so such items
// can be accepted back to back while the output stage is free. A list of n
// stored elements streams n result items, as the single read port of the slot
// memory fetches one element per cycle while the output is not stalled; input
// is stalled while the walk runs. No clearing pass follows reset.
module double_ended_queue_core #(
  parameter int CAPACITY   = dq_pkg::DQ_CAPACITY,
  parameter int DATA_WIDTH = dq_pkg::DQ_DATA_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [2:0]                   command,
  input  logic signed [DATA_WIDTH-1:0] value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [1:0]                   status,
  output logic signed [DATA_WIDTH-1:0] element,
  output logic                         last
);
  import dq_pkg::*;

  localparam int IW = $clog2(CAPACITY);

  res_t                  res;
  logic                  out_free;
  logic                  wr_en;
  logic [IW-1:0]         wr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic                  rd_en;
  logic [IW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rd_data;

  // Controller.
  dq_ctrl #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command (command),
    .value   (value),
    .out_free(out_free),
    .res     (res),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr)
  );

  // Slot memory.
  dq_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(CAPACITY)
  ) u_slots (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  // Result register.
  dq_outreg #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_out (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .rd_data  (rd_data),
    .out_free (out_free),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .element  (element),
    .last     (last)
  );

endmodule

FILE: rtl/dq_checker.sv
// Port-level checks for the double-ended queue core, and the bind that attaches them.
// Depends on dq_pkg and on double_ended_queue_core.
module dq_checker #(
  parameter int DATA_WIDTH = dq_pkg::DQ_DATA_WIDTH
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [1:0]            status,
  input logic [DATA_WIDTH-1:0] element,
  input logic                  last
);
  import dq_pkg::*;

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(element)
      && $stable(last))
    else $error("stalled result changed");

  // Only defined status codes appear.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_EMPTY || status == ST_FULL))
    else $error("undefined status code");

  // Empty and full results carry a zero element and close their item.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> element == '0 && last)
    else $error("error result with element or without last");

  // While a list walk is mid-stream, no new item is taken.
  a_list_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> in_stall)
    else $error("input accepted during a list walk");

endmodule

bind double_ended_queue_core dq_checker #(
  .DATA_WIDTH(DATA_WIDTH)
) u_dq_checker (
  .clk      (clk),
  .rst      (rst),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .status   (status),
  .element  (element),
  .last     (last)
);
